// ----- hdl/mmf_pkg.sv -----
// Package for the MIDI message framer: byte codes, packet counts and the
// result record. Used by midi_message_framer_top; depends on nothing.
`default_nettype none

package mmf_pkg;

    localparam logic [7:0] ACTIVE_SENSE  = 8'd254;
    localparam logic [6:0] ALL_NOTES_OFF = 7'd123;

    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_CTRL     = 4'hB;

    localparam logic [1:0] CNT_NONE   = 2'd0;
    localparam logic [1:0] CNT_STATUS = 2'd1;
    localparam logic [1:0] CNT_DATA   = 2'd2;

    localparam logic [1:0] LEN_SHORT = 2'd2;
    localparam logic [1:0] LEN_FULL  = 2'd3;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic [1:0] byte_count;
    } t_result;

    function automatic logic is_framed_status(input logic [7:0] b);
        return (b[7:4] == NIB_NOTE_OFF) || (b[7:4] == NIB_NOTE_ON) || (b[7:4] == NIB_CTRL);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/midi_message_framer_top.sv -----
// MIDI message framer: running-status parser that frames bytes into packets.
// Depends on mmf_pkg.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one received MIDI byte per beat
//   with a sink-full flag; a byte with the flag set, and active sensing, are
//   dropped. Output channel (o_valid / i_ready) carries one packet per beat:
//   status byte, one or two data bytes and the byte count (2 or 3).
//   Throughput: one byte per cycle while o_ready is high; the parser state is
//   updated in the cycle the byte is taken, so bytes may arrive back to back.
//   A result register plus a one-entry skid register sit on the output, so a
//   byte is still taken while a finished packet waits. When the receiver
//   stalls and both hold a packet, o_ready drops until the result register
//   drains.
//   Reset (i_rst_n low, synchronous) clears the running status, the open
//   packet and both output stages.
`default_nettype none

module midi_message_framer_top
    import mmf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_sink_full,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_status_byte,
    output logic [7:0]      o_first_data,
    output logic [7:0]      o_second_data,
    output logic [1:0]      o_byte_count
);

    logic [7:0] r_running, n_running;
    logic [1:0] r_count, n_count;
    logic [7:0] r_held, n_held;

    t_result    r_out, r_skid;
    logic       r_out_valid, r_skid_valid;

    t_result    n_res;
    logic       n_emit;
    logic       in_beat, out_beat;

    assign o_ready  = !r_skid_valid;
    assign in_beat  = i_valid && o_ready;
    assign out_beat = r_out_valid && i_ready;

    always_comb begin
        n_running = r_running;
        n_count   = r_count;
        n_held    = r_held;
        n_emit    = 1'b0;
        n_res     = '{status_byte: r_running, first_data: r_held,
                      second_data: i_rx_byte, byte_count: LEN_FULL};
        if (in_beat && i_rx_byte != ACTIVE_SENSE && !i_sink_full) begin
            if (is_framed_status(i_rx_byte)) begin
                n_running = i_rx_byte;
                n_count   = CNT_STATUS;
            end else if (r_count == CNT_DATA) begin
                n_emit  = 1'b1;
                n_count = CNT_NONE;
            end else if (r_count == CNT_STATUS && i_rx_byte[6:0] == ALL_NOTES_OFF) begin
                n_emit  = 1'b1;
                n_res   = '{status_byte: r_running, first_data: i_rx_byte,
                            second_data: 8'd0, byte_count: LEN_SHORT};
                n_count = CNT_NONE;
            end else if (r_count == CNT_STATUS || !i_rx_byte[7]) begin
                n_held  = i_rx_byte;
                n_count = CNT_DATA;
            end else begin
                n_count = CNT_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= '0;
            r_count      <= CNT_NONE;
            r_held       <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_running <= n_running;
            r_count   <= n_count;
            r_held    <= n_held;
            if (r_skid_valid) begin
                if (out_beat) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (n_emit) begin
                if (!r_out_valid || out_beat) begin
                    r_out       <= n_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= n_res;
                    r_skid_valid <= 1'b1;
                end
            end else if (out_beat) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status_byte = r_out.status_byte;
    assign o_first_data  = r_out.first_data;
    assign o_second_data = r_out.second_data;
    assign o_byte_count  = r_out.byte_count;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while result register empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("open packet count out of range");

    a_short_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.byte_count == LEN_FULL) ||
                         (r_out.byte_count == LEN_SHORT && r_out.second_data == 8'd0)))
        else $error("bad packet length or nonzero second byte in short packet");

    a_drop_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (i_sink_full || i_rx_byte == ACTIVE_SENSE)) |=>
            ($stable(r_running) && $stable(r_count) && $stable(r_held)))
        else $error("dropped byte changed parser state");

endmodule

`default_nettype wire

// ----- test/midi_message_framer_top_test.sv -----
`timescale 1ns / 1ps
// Testbench for midi_message_framer_top: a directed table, then random MIDI byte streams,
// each packet checked against a built-in running-status framer. Depends on mmf_pkg.

module midi_message_framer_top_test;
    import mmf_pkg::*;

    localparam int BYTE_GOAL   = 1550;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] rx;
        logic       full;
        logic       typed;
        logic       has_pkt;
        t_result    pkt;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_sink_full = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_status_byte;
    logic [7:0] o_first_data;
    logic [7:0] o_second_data;
    logic [1:0] o_byte_count;

    logic [7:0] run_status = 8'h00;
    logic [1:0] open_count = CNT_NONE;
    logic [7:0] first_held = 8'h00;

    t_result    pending_packets [$];
    t_row       plan [0:24];
    int         bytes_taken = 0;
    int         errors = 0;
    int         cycles = 0;
    int         stall_left = 0;
    bit         held_off = 1'b0;
    wire        steady = (bytes_taken >= 200) && (bytes_taken < 500);

    midi_message_framer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .i_sink_full   (i_sink_full),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status_byte (o_status_byte),
        .o_first_data  (o_first_data),
        .o_second_data (o_second_data),
        .o_byte_count  (o_byte_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit frame_byte(input logic [7:0] b, input logic full,
                                      output t_result pkt);
        logic [3:0] hi;
        bit         done;
        hi = b[7:4];
        done = 1'b0;
        pkt = '0;
        if (b == ACTIVE_SENSE || full)
            return 1'b0;
        if (hi == NIB_NOTE_OFF || hi == NIB_NOTE_ON || hi == NIB_CTRL) begin
            run_status = b;
            open_count = CNT_STATUS;
        end else if (open_count == CNT_DATA) begin
            pkt = '{run_status, first_held, b, LEN_FULL};
            open_count = CNT_NONE;
            done = 1'b1;
        end else if (open_count == CNT_STATUS && b[6:0] == ALL_NOTES_OFF) begin
            pkt = '{run_status, b, 8'h00, LEN_SHORT};
            open_count = CNT_NONE;
            done = 1'b1;
        end else if (open_count == CNT_STATUS || !b[7]) begin
            first_held = b;
            open_count = CNT_DATA;
        end else begin
            open_count = CNT_NONE;
        end
        return done;
    endfunction

    function automatic t_row plain(input logic [7:0] b, input logic f);
        t_row r;
        r = '0;
        r.rx = b;
        r.full = f;
        return r;
    endfunction

    function automatic logic [7:0] data_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return {1'b0, ALL_NOTES_OFF};
        if (pick < 16)
            return {1'b1, ALL_NOTES_OFF};
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic send_beat(input t_row r);
        t_result pkt;
        bit      got;
        while (!steady && $urandom_range(0, 99) < 23) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_rx_byte   <= r.rx;
        i_sink_full <= r.full;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        got = frame_byte(r.rx, r.full, pkt);
        if (r.typed) begin
            if (r.has_pkt)
                pending_packets.push_back(r.pkt);
        end else if (got) begin
            pending_packets.push_back(pkt);
        end
        if (!(r.rx == ACTIVE_SENSE || r.full))
            bytes_taken++;
        @(negedge i_clk);
    endtask

    // interleave an ignored beat now and then inside a message
    task automatic send_data(input logic [7:0] b);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            send_beat(plain(ACTIVE_SENSE, 1'($urandom_range(0, 1))));
        else if (pick < 6)
            send_beat(plain(8'($urandom_range(0, 255)), 1'b1));
        send_beat(plain(b, 1'b0));
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if (!held_off && bytes_taken >= 250) begin
            held_off = 1'b1;
            stall_left = 59;
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(0, 99) >= 23);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_packets.size() == 0) begin
                $display("%0t: unexpected packet, expected none, actual %h %h %h %0d",
                         $time, o_status_byte, o_first_data, o_second_data, o_byte_count);
                errors++;
            end else begin
                want = pending_packets.pop_front();
                check_field("status_byte", want.status_byte, o_status_byte);
                check_field("first_data", want.first_data, o_first_data);
                check_field("second_data", want.second_data, o_second_data);
                check_field("byte_count", {6'd0, want.byte_count}, {6'd0, o_byte_count});
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [7:0] first;
        logic [3:0] nib;
        int         pick;
        plan = '{
            '{8'h00, 1'b0, 1'b0, 1'b0, '0},
            '{8'h7F, 1'b0, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h7F, LEN_FULL}},
            '{8'hFE, 1'b1, 1'b1, 1'b0, '0},
            '{8'h90, 1'b0, 1'b0, 1'b0, '0},
            '{8'h3C, 1'b1, 1'b1, 1'b0, '0},
            '{8'h3C, 1'b0, 1'b0, 1'b0, '0},
            '{8'h40, 1'b0, 1'b1, 1'b1, '{8'h90, 8'h3C, 8'h40, LEN_FULL}},
            '{8'h7B, 1'b0, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, 1'b0, '0},
            '{8'hB5, 1'b0, 1'b0, 1'b0, '0},
            '{8'h7B, 1'b0, 1'b1, 1'b1, '{8'hB5, 8'h7B, 8'h00, LEN_SHORT}},
            '{8'h80, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFB, 1'b0, 1'b1, 1'b1, '{8'h80, 8'hFB, 8'h00, LEN_SHORT}},
            '{8'hC0, 1'b0, 1'b0, 1'b0, '0},
            '{8'h9F, 1'b0, 1'b0, 1'b0, '0},
            '{8'h8F, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFE, 1'b0, 1'b1, 1'b0, '0},
            '{8'hF0, 1'b0, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, 1'b0, '0},
            '{8'h90, 1'b0, 1'b0, 1'b0, '0},
            '{8'h7F, 1'b0, 1'b0, 1'b0, '0},
            '{8'h85, 1'b1, 1'b1, 1'b0, '0},
            '{8'h7B, 1'b0, 1'b0, 1'b0, '0}
        };
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < 25; i++)
            send_beat(plain(8'h00, 1'b0) | plan[i]);

        while (bytes_taken < BYTE_GOAL) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_beat(plain(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0));
            end else if (pick < 25) begin
                send_data(data_byte());
            end else begin
                case ($urandom_range(0, 2))
                    0: nib = NIB_NOTE_OFF;
                    1: nib = NIB_NOTE_ON;
                    default: nib = NIB_CTRL;
                endcase
                send_beat(plain({nib, 4'($urandom_range(0, 15))}, 1'b0));
                first = data_byte();
                send_data(first);
                if (first[6:0] != ALL_NOTES_OFF)
                    send_data(data_byte());
            end
        end

        i_valid <= 1'b0;
        while (pending_packets.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/mmf_pkg.sv
hdl/midi_message_framer_top.sv
test/midi_message_framer_top_test.sv
